// File: sv/bam_pkg.sv
// ----------------------------------------------------------------------------
// bam_pkg
// Shared types and constants of the bump allocator with mark and compact.
// ----------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

    localparam int HEAP_UNITS = 64;
    localparam int UNIT_BYTES = 8;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 10;
    localparam int UNIT_W  = $clog2(HEAP_UNITS);
    localparam int CNT_W   = $clog2(HEAP_UNITS + 1);
    localparam int SZU_W   = $clog2((((1 << SIZE_W) + UNIT_BYTES - 2) / UNIT_BYTES) + 1);
    localparam int CIDX_W  = 2;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_MARK    = 2'd1;
    localparam logic [1:0] ACT_COMPACT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_MARK = 2'd2;

    localparam logic [CIDX_W-1:0] REG_HEAP_BASE    = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_UNITS_IN_USE = CIDX_W'(1);

    localparam logic [CNT_W-1:0] UNITS_RESET = CNT_W'(HEAP_UNITS);

    typedef struct packed {
        logic [1:0]        action;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] object_address;
        logic [ADDR_W-1:0] dest_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  unit_count;
        logic [ADDR_W-1:0] copy_dest;
        logic [ADDR_W-1:0] end_address;
        logic              last;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/bam_ram.sv
// ----------------------------------------------------------------------------
// bam_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/bam_out_buf.sv
// ----------------------------------------------------------------------------
// bam_out_buf
// Output register of the result channel, holds one transaction under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bam_pkg::t_out_item i_data,
    output logic                    o_free,
    output logic                    o_valid,
    output bam_pkg::t_out_item      o_data,
    input  wire logic               i_stall
);

    logic               r_vld;
    bam_pkg::t_out_item r_data;

    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/bump_allocator_mark_compact.sv
// ----------------------------------------------------------------------------
// bump_allocator_mark_compact
// Bump allocator over a unit heap with start and end bitmaps in RAM; compact
// walks the used units and emits one copy command per live object.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out      out  o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  allocate and mark: capture, then execute; input stalls until done
//  compact: S_CREAD then S_CEVAL per used unit, one bitmap RAM read per unit
//  after reset a clearing pass over all HEAP_UNITS units runs before input opens
//  a full output register holds back execution until it drains
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_mark_compact (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire bam_pkg::t_in_item                     i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output bam_pkg::t_out_item                         o_out_data,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [bam_pkg::CIDX_W-1:0]            i_cfg_index,
    input  wire logic [bam_pkg::ADDR_W-1:0]            i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_EXEC,
        S_CREAD,
        S_CEVAL,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [bam_pkg::UNIT_W-1:0]      r_q;
    logic [bam_pkg::CNT_W-1:0]       r_next;
    logic [bam_pkg::ADDR_W-1:0]      r_base;
    logic [bam_pkg::CNT_W-1:0]       r_cap_reg;
    bam_pkg::t_in_item               r_in;
    logic                            r_in_obj;
    logic [bam_pkg::UNIT_W-1:0]      r_start;
    logic [bam_pkg::ADDR_W-1:0]      r_dest;
    bam_pkg::t_out_item              r_pend;
    logic                            r_pend_vld;

    logic                            out_free;
    logic                            push;
    bam_pkg::t_out_item              push_data;

    logic                            rd_start;
    logic                            rd_end;
    logic                            ram_we;
    logic                            mark_wr;
    logic [bam_pkg::UNIT_W-1:0]      start_waddr;
    logic [bam_pkg::UNIT_W-1:0]      end_waddr;

    logic [bam_pkg::CNT_W-1:0]       cap;
    logic [bam_pkg::SZU_W-1:0]       req_units;
    logic [bam_pkg::SZU_W-1:0]       mark_units;
    logic [bam_pkg::SZU_W:0]         alloc_sum;
    logic                            alloc_fail;
    logic [bam_pkg::ADDR_W-1:0]      alloc_addr;
    logic [bam_pkg::ADDR_W-1:0]      mark_off;
    logic [bam_pkg::ADDR_W-1:0]      mark_idx_full;
    logic                            mark_bad;
    logic [bam_pkg::SZU_W:0]         mark_end_full;
    logic [bam_pkg::UNIT_W-1:0]      mark_end;

    logic                            at_end;
    logic                            opens;
    logic                            closes;
    logic [bam_pkg::UNIT_W-1:0]      obj_start;
    logic [bam_pkg::CNT_W-1:0]       obj_len;
    logic [bam_pkg::ADDR_W-1:0]      c_next_dest;
    logic [bam_pkg::ADDR_W-1:0]      c_src;
    logic                            eval_wait;
    logic                            advance;
    bam_pkg::t_out_item              new_pend;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // allocate and mark arithmetic
    always_comb begin
        cap = (r_cap_reg > bam_pkg::UNITS_RESET) ? bam_pkg::UNITS_RESET : r_cap_reg;
        req_units = bam_pkg::SZU_W'(
            ({1'b0, r_in.size_bytes} + (bam_pkg::SIZE_W + 1)'(bam_pkg::UNIT_BYTES - 1))
            >> bam_pkg::UNIT_SHIFT);
        mark_units = (req_units == '0) ? bam_pkg::SZU_W'(1) : req_units;
        alloc_sum  = (bam_pkg::SZU_W + 1)'(r_next) + (bam_pkg::SZU_W + 1)'(req_units);
        alloc_fail = alloc_sum > (bam_pkg::SZU_W + 1)'(cap);
        alloc_addr = r_base + bam_pkg::ADDR_W'(r_next) * bam_pkg::ADDR_W'(bam_pkg::UNIT_BYTES);

        mark_off      = r_in.object_address - r_base;
        mark_idx_full = mark_off >> bam_pkg::UNIT_SHIFT;
        mark_bad      = (r_in.object_address < r_base)
                     || (mark_idx_full >= bam_pkg::ADDR_W'(r_next));
        mark_end_full = (bam_pkg::SZU_W + 1)'(mark_idx_full[bam_pkg::UNIT_W-1:0])
                      + (bam_pkg::SZU_W + 1)'(mark_units) - (bam_pkg::SZU_W + 1)'(1);
        if (mark_end_full >= (bam_pkg::SZU_W + 1)'(r_next)) begin
            mark_end = bam_pkg::UNIT_W'(r_next - bam_pkg::CNT_W'(1));
        end else begin
            mark_end = mark_end_full[bam_pkg::UNIT_W-1:0];
        end
    end

    // compaction scan
    always_comb begin
        at_end      = (bam_pkg::CNT_W'(r_q) == r_next - bam_pkg::CNT_W'(1));
        opens       = !r_in_obj && rd_start;
        obj_start   = r_in_obj ? r_start : r_q;
        closes      = (r_in_obj || rd_start) && (rd_end || at_end);
        obj_len     = bam_pkg::CNT_W'(r_q) - bam_pkg::CNT_W'(obj_start) + bam_pkg::CNT_W'(1);
        c_next_dest = r_dest + bam_pkg::ADDR_W'(obj_len)
                    * bam_pkg::ADDR_W'(bam_pkg::UNIT_BYTES);
        c_src       = r_base + bam_pkg::ADDR_W'(obj_start)
                    * bam_pkg::ADDR_W'(bam_pkg::UNIT_BYTES);
        eval_wait   = closes && r_pend_vld && !out_free;
        advance     = (r_state == S_CEVAL) && !eval_wait;

        new_pend             = '0;
        new_pend.status      = bam_pkg::ST_OK;
        new_pend.address     = c_src;
        new_pend.unit_count  = obj_len;
        new_pend.copy_dest   = r_dest;
        new_pend.end_address = c_next_dest;
        new_pend.last        = 1'b0;
    end

    // result selection
    always_comb begin
        push      = 1'b0;
        push_data = '0;
        mark_wr   = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_in.action)
                    bam_pkg::ACT_ALLOC: begin
                        push           = out_free;
                        push_data.last = 1'b1;
                        if (alloc_fail) begin
                            push_data.status = bam_pkg::ST_NO_SPACE;
                        end else begin
                            push_data.status  = bam_pkg::ST_OK;
                            push_data.address = alloc_addr;
                        end
                    end
                    bam_pkg::ACT_MARK: begin
                        push             = out_free;
                        push_data.last   = 1'b1;
                        push_data.status = mark_bad ? bam_pkg::ST_BAD_MARK : bam_pkg::ST_OK;
                        mark_wr          = out_free && !mark_bad;
                    end
                    default: begin
                        push = 1'b0;
                    end
                endcase
            end
            S_CEVAL: begin
                push      = advance && closes && r_pend_vld;
                push_data = r_pend;
            end
            S_FIN: begin
                push = out_free;
                if (r_pend_vld) begin
                    push_data      = r_pend;
                    push_data.last = 1'b1;
                end else begin
                    push_data.status      = bam_pkg::ST_OK;
                    push_data.copy_dest   = r_dest;
                    push_data.end_address = r_dest;
                    push_data.last        = 1'b1;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign ram_we      = (r_state == S_CLR) || advance || mark_wr;
    assign start_waddr = mark_wr ? mark_idx_full[bam_pkg::UNIT_W-1:0] : r_q;
    assign end_waddr   = mark_wr ? mark_end : r_q;

    bam_ram #(
        .DEPTH  (bam_pkg::HEAP_UNITS),
        .DATA_W (1)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (start_waddr),
        .i_wdata (mark_wr),
        .i_raddr (r_q),
        .o_rdata (rd_start)
    );

    bam_ram #(
        .DEPTH  (bam_pkg::HEAP_UNITS),
        .DATA_W (1)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (end_waddr),
        .i_wdata (mark_wr),
        .i_raddr (r_q),
        .o_rdata (rd_end)
    );

    bam_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_q        <= '0;
            r_next     <= '0;
            r_base     <= '0;
            r_cap_reg  <= bam_pkg::UNITS_RESET;
            r_in_obj   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == bam_pkg::REG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == bam_pkg::REG_UNITS_IN_USE) begin
                    r_cap_reg <= i_cfg_data[bam_pkg::CNT_W-1:0];
                end
            end
            case (r_state)
                S_CLR: begin
                    r_q <= r_q + bam_pkg::UNIT_W'(1);
                    if (r_q == bam_pkg::UNIT_W'(bam_pkg::HEAP_UNITS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in <= i_in_data;
                        if (i_in_data.action == bam_pkg::ACT_COMPACT) begin
                            r_dest     <= i_in_data.dest_address;
                            r_q        <= '0;
                            r_in_obj   <= 1'b0;
                            r_pend_vld <= 1'b0;
                            r_state    <= (r_next == '0) ? S_FIN : S_CREAD;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (r_in.action == bam_pkg::ACT_ALLOC) begin
                        if (out_free) begin
                            if (!alloc_fail) begin
                                r_next <= bam_pkg::CNT_W'(alloc_sum);
                            end
                            r_state <= S_IDLE;
                        end
                    end else if (r_in.action == bam_pkg::ACT_MARK) begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CREAD: begin
                    r_state <= S_CEVAL;
                end
                S_CEVAL: begin
                    if (advance) begin
                        if (closes) begin
                            r_pend     <= new_pend;
                            r_pend_vld <= 1'b1;
                            r_dest     <= c_next_dest;
                            r_in_obj   <= 1'b0;
                        end else if (opens) begin
                            r_in_obj <= 1'b1;
                            r_start  <= r_q;
                        end
                        if (at_end) begin
                            r_state <= S_FIN;
                        end else begin
                            r_q     <= r_q + bam_pkg::UNIT_W'(1);
                            r_state <= S_CREAD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_next     <= '0;
                        r_pend_vld <= 1'b0;
                        r_q        <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
